// File: hw/rtl/lbpc_pkg.sv
// Shared types and constants of the LED blink pattern classifier.
package lbpc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned PulseW   = 16;
  localparam int unsigned ThrW     = 14;

  typedef enum logic [2:0] {
    ST_UNKNOWN = 3'd0,
    ST_OFF     = 3'd1,
    ST_SLOW    = 3'd2,
    ST_FAST    = 3'd3,
    ST_ON      = 3'd4
  } led_state_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FAST_PERIOD = 3'd0,
    REG_SLOW_PERIOD = 3'd1,
    REG_TOLERANCE   = 3'd2,
    REG_STEADY_THR  = 3'd3,
    REG_DEBOUNCE    = 3'd4
  } cfg_reg_e;

  localparam logic [15:0]     FastPeriodRst = 16'd100;
  localparam logic [15:0]     SlowPeriodRst = 16'd1000;
  localparam logic [15:0]     ToleranceRst  = 16'd10;
  localparam logic [ThrW-1:0] SteadyThrRst  = 14'd2000;
  localparam logic [15:0]     DebounceRst   = 16'd2;

endpackage

// File: hw/rtl/lbpc_if.sv
// Valid/ready channel interfaces for pin samples, results and register writes.
interface lbpc_pin_if;
  logic valid;
  logic ready;
  logic pin_level;
  modport source (output valid, output pin_level, input ready);
  modport sink (input valid, input pin_level, output ready);
endinterface

interface lbpc_res_if;
  import lbpc_pkg::*;
  logic        valid;
  logic        ready;
  led_state_e  led_state;
  logic        state_changed;
  logic [15:0] last_pulse_ms;
  modport source (output valid, output led_state, output state_changed,
                  output last_pulse_ms, input ready);
  modport sink (input valid, input led_state, input state_changed,
                input last_pulse_ms, output ready);
endinterface

interface lbpc_cfg_if;
  import lbpc_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/led_blink_pattern_classifier_core.sv
// Top level of the LED blink pattern classifier: per-tick edge, pulse and steady logic.
// The result word of an accepted tick word is registered and valid in the next cycle.
// Throughput: one tick word per cycle while results are taken, set by the single registered update of the state.
// The result register is released when taken and refilled in the same cycle.
// Reset (asynchronous, active low) restores the default registers, pin level high,
// counters zero, state unknown and an empty result register.
module led_blink_pattern_classifier_core #(
  parameter int unsigned TIME_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lbpc_pin_if.sink   pin_i,
  lbpc_res_if.source res_o,
  lbpc_cfg_if.sink   cfg_i
);
  import lbpc_pkg::*;

  // Comparisons run at the wider of the counter and the 16-bit register width.
  localparam int unsigned CW = (TIME_BITS > 16) ? TIME_BITS : 16;
  localparam logic [CW-1:0] PulseMax = CW'({PulseW{1'b1}});

  // Configuration registers.
  logic [15:0]     fast_q, slow_q, tol_q, deb_q;
  logic [ThrW-1:0] thr_q;

  // Classifier state.
  logic                 prev_q;
  logic [TIME_BITS-1:0] elapsed_q, elapsed_d;
  logic [TIME_BITS-1:0] pulse_q, pulse_d;
  led_state_e           state_q, state_d;

  // Result register.
  logic        res_valid_q;
  led_state_e  res_state_q;
  logic        res_changed_q;
  logic [15:0] res_pulse_q;

  logic                 accept;
  logic [TIME_BITS-1:0] elapsed_inc, since_edge;
  logic                 lvl_edge, fast_hit, slow_hit, steady;
  led_state_e           state_mid;
  logic [15:0]          thr3;
  logic [CW-1:0]        pulse_ext;

  // A new word is taken whenever the result register is empty or is drained now.
  assign pin_i.ready = !res_valid_q || res_o.ready;
  assign accept      = pin_i.valid && pin_i.ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_q <= FastPeriodRst;
      slow_q <= SlowPeriodRst;
      tol_q  <= ToleranceRst;
      thr_q  <= SteadyThrRst;
      deb_q  <= DebounceRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_FAST_PERIOD: fast_q <= cfg_i.data;
        REG_SLOW_PERIOD: slow_q <= cfg_i.data;
        REG_TOLERANCE:   tol_q  <= cfg_i.data;
        REG_STEADY_THR:  thr_q  <= cfg_i.data[ThrW-1:0];
        REG_DEBOUNCE:    deb_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // The pulse length seen by the matchers is the advanced counter value.
  lbpc_match #(.TIME_BITS(TIME_BITS)) u_fast (
    .len_i(elapsed_inc), .nominal_i(fast_q), .tol_i(tol_q), .hit_o(fast_hit)
  );

  lbpc_match #(.TIME_BITS(TIME_BITS)) u_slow (
    .len_i(elapsed_inc), .nominal_i(slow_q), .tol_i(tol_q), .hit_o(slow_hit)
  );

  always_comb begin
    // The counter advances first and saturates at all ones.
    elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + TIME_BITS'(1);

    // A level change counts only once the debounce window has passed.
    lvl_edge = (pin_i.pin_level != prev_q) && (CW'(elapsed_inc) > CW'(deb_q));

    state_mid = state_q;
    pulse_d   = pulse_q;
    if (lvl_edge) begin
      pulse_d = elapsed_inc;
      // Fast wins when both periods match; a pulse near neither keeps the state.
      if (fast_hit) begin
        state_mid = ST_FAST;
      end else if (slow_hit) begin
        state_mid = ST_SLOW;
      end
    end
    since_edge = lvl_edge ? '0 : elapsed_inc;
    elapsed_d  = since_edge;

    // Steady check: beyond the threshold, and either below three thresholds or
    // while nothing has been classified yet. The pin is active low.
    thr3   = 16'({2'b00, thr_q}) + 16'({1'b0, thr_q, 1'b0});
    steady = (CW'(since_edge) > CW'(thr_q)) &&
             ((CW'(since_edge) < CW'(thr3)) || (state_mid == ST_UNKNOWN));
    state_d = state_mid;
    if (steady) begin
      state_d = pin_i.pin_level ? ST_OFF : ST_ON;
    end

    pulse_ext = CW'(pulse_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= 1'b1;
      elapsed_q <= '0;
      pulse_q   <= '0;
      state_q   <= ST_UNKNOWN;
    end else if (accept) begin
      prev_q    <= pin_i.pin_level;
      elapsed_q <= elapsed_d;
      pulse_q   <= pulse_d;
      state_q   <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (accept) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  // Payload of the result word; the reported pulse saturates at 16 bits.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_state_q   <= state_d;
      res_changed_q <= (state_d != state_q);
      res_pulse_q   <= (pulse_ext > PulseMax) ? PulseMax[15:0] : pulse_ext[15:0];
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.led_state     = res_state_q;
  assign res_o.state_changed = res_changed_q;
  assign res_o.last_pulse_ms = res_pulse_q;
endmodule

// File: hw/rtl/lbpc_match.sv
// Tests whether a pulse length lies strictly within tolerance of a nominal period.
module lbpc_match #(
  parameter int unsigned TIME_BITS = 16
) (
  input  logic [TIME_BITS-1:0] len_i,
  input  logic [15:0]          nominal_i,
  input  logic [15:0]          tol_i,
  output logic                 hit_o
);
  localparam int unsigned CW = (TIME_BITS > 16) ? TIME_BITS : 16;

  logic [CW-1:0] len_ext, nom_ext, gap;

  always_comb begin
    len_ext = CW'(len_i);
    nom_ext = CW'(nominal_i);
    gap     = (len_ext >= nom_ext) ? (len_ext - nom_ext) : (nom_ext - len_ext);
    hit_o   = gap < CW'(tol_i);
  end
endmodule

// File: hw/rtl/lbpc_checker.sv
// Port-level assertions for the LED blink pattern classifier, bound to the top level.
module lbpc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input lbpc_pkg::led_state_e out_state_i,
  input logic              out_changed_i,
  input logic [15:0]       out_pulse_i
);
  import lbpc_pkg::*;

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_state_i) &&
      $stable(out_changed_i) && $stable(out_pulse_i))
    else $error("stalled result word changed");

  // Every accepted tick word yields a result word in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted tick word produced no result");

  // A drained result with no new tick leaves the output empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !(in_valid_i && in_ready_i) |=> !out_valid_i)
    else $error("result word repeated");

  // A blink classification only follows an accepted pulse of non-zero length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_state_i == ST_FAST || out_state_i == ST_SLOW) |->
      out_pulse_i != 16'd0)
    else $error("blink state without a recorded pulse");
endmodule

bind led_blink_pattern_classifier_core lbpc_checker u_lbpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (pin_i.valid),
  .in_ready_i    (pin_i.ready),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .out_state_i   (res_o.led_state),
  .out_changed_i (res_o.state_changed),
  .out_pulse_i   (res_o.last_pulse_ms)
);
